/* hdl/hgs_pkg.sv */
// ---------------------------------------------------------------------------
// Hydrostatic geopotential scan package
// Shared widths, constants and status types for the scan datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package hgs_pkg;

    localparam int DATA_W    = 32;                 // Q20.12 inputs, Q16.16 gas constant
    localparam int GEO_W     = 48;                 // Q32.16 geopotential
    localparam int RATIO_W   = 26;                 // Q2.24 ratio
    localparam int TERM_W    = GEO_W - 1;          // term is never negative
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    localparam logic [RATIO_W-1:0] RATIO_MAX          = '1;
    localparam logic [DATA_W-1:0]  GAS_CONSTANT_RESET = 32'd18811453;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

/* hdl/hydrostatic_geopotential_scan_top.sv */
// ---------------------------------------------------------------------------
// Hydrostatic geopotential scan
// Integrates geopotential up a column, one level per beat, bottom first.
//
//   Channel  Dir  Handshake         Contents (low bit first)
//   s_       in   s_tvalid/tready   tdata: thickness, pressure, temp, surface
//                                   tuser: first_level
//   m_       out  m_tvalid/tready   tdata: level_geopotential; tuser: error
//   cfg_     in   cfg_we            cfg_wdata: gas_constant
//
// A level passes from accept to result through the radix-2 divider, the
// shared multiplier, then the sequencing and sums.
// A zero pressure skips both units; a saturated ratio skips the
// divider. s_tready is high only while the sequencer is idle.
// A result waits in the output register while the next beat is accepted;
// a stalled m_ side holds the sequencer only at its final step.
// Reset clears the accumulator and loads the default gas constant.
// ---------------------------------------------------------------------------
`default_nettype none

module hydrostatic_geopotential_scan_top
    import hgs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // [31:0] layer_thickness, [63:32] level_pressure, [95:64] virtual_temp,
    // [143:96] surface_geopotential
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,   // [0] first_level
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [47:0] level_geopotential
    output logic [0:0]                m_tuser,   // [0] error
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic [DATA_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LAUNCH,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [DATA_W-1:0]       gc_reg;
    logic [DATA_W-1:0]       tv_reg;
    logic [RATIO_W-1:0]      ratio_reg;
    logic [TERM_W-1:0]       term_reg;
    logic signed [GEO_W-1:0] surface_reg;
    logic signed [GEO_W-1:0] acc_reg;
    logic signed [GEO_W:0]   part_reg;
    logic                    err_reg;
    logic                    p_zero_reg;
    logic [GEO_W-1:0]        m_data_reg;
    logic                    m_err_reg;
    logic                    m_valid_reg;

    logic [DATA_W-1:0] in_dp;
    logic [DATA_W-1:0] in_p;
    logic              accept;
    logic              in_p_zero;
    logic              in_ovf;
    logic              div_start;
    logic              term_start;

    unit_status_t       div_stat;
    unit_status_t       term_stat;
    logic [RATIO_W-1:0] div_quo;
    logic [TERM_W-1:0]  term_out;

    logic signed [GEO_W:0]   acc_sum;
    logic signed [GEO_W:0]   part_sum;
    logic signed [GEO_W+1:0] phi_sum;
    logic signed [GEO_W-1:0] acc_sat;
    logic signed [GEO_W-1:0] phi_sat;
    logic                    out_free;

    localparam logic signed [GEO_W-1:0] GEO_MAX = {1'b0, {(GEO_W-1){1'b1}}};
    localparam logic signed [GEO_W-1:0] GEO_MIN = {1'b1, {(GEO_W-1){1'b0}}};

    assign in_dp     = s_tdata[31:0];
    assign in_p      = s_tdata[63:32];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_p_zero = (in_p == '0);
    // ratio exceeds Q2.24 range exactly when thickness >= 4 * pressure
    assign in_ovf    = ({2'b00, in_dp} >= {in_p, 2'b00});
    assign div_start = accept && !in_p_zero && !in_ovf;
    assign term_start = (state_reg == ST_LAUNCH);

    hgs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (in_dp),
        .divisor  (in_p),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    hgs_term u_term (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (term_start),
        .gas_constant (gc_reg),
        .virtual_temp (tv_reg),
        .ratio        (ratio_reg),
        .stat         (term_stat),
        .term         (term_out)
    );

    assign acc_sum  = {acc_reg[GEO_W-1], acc_reg} + {2'b00, term_reg};
    assign part_sum = {surface_reg[GEO_W-1], surface_reg}
                    + {acc_reg[GEO_W-1], acc_reg};
    assign phi_sum  = {part_reg[GEO_W], part_reg} + {4'b0000, term_reg[TERM_W-1:1]};

    always_comb begin
        if (acc_sum[GEO_W] != acc_sum[GEO_W-1]) begin
            acc_sat = acc_sum[GEO_W] ? GEO_MIN : GEO_MAX;
        end else begin
            acc_sat = acc_sum[GEO_W-1:0];
        end
        if ((phi_sum[GEO_W+1] != phi_sum[GEO_W])
                || (phi_sum[GEO_W] != phi_sum[GEO_W-1])) begin
            phi_sat = phi_sum[GEO_W+1] ? GEO_MIN : GEO_MAX;
        end else begin
            phi_sat = phi_sum[GEO_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gc_reg      <= GAS_CONSTANT_RESET;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gc_reg <= cfg_wdata;
            end
            // the final step reloads the output register itself
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        tv_reg      <= s_tdata[95:64];
                        surface_reg <= s_tdata[143:96];
                        p_zero_reg  <= in_p_zero;
                        err_reg     <= in_p_zero || in_ovf;
                        ratio_reg   <= RATIO_MAX;
                        term_reg    <= '0;
                        if (s_tuser[0]) begin
                            acc_reg <= '0;
                        end
                        if (in_p_zero) begin
                            state_reg <= ST_SUM;
                        end else if (in_ovf) begin
                            state_reg <= ST_LAUNCH;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        ratio_reg <= div_quo;
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (term_stat.done) begin
                        term_reg  <= term_out;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    // old accumulator feeds the level sum, then advance it
                    part_reg  <= part_sum;
                    acc_reg   <= acc_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg  <= phi_sat;
                        m_err_reg   <= err_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;
    assign m_tvalid = m_valid_reg;

    a_zero_p_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) && p_zero_reg |-> (term_reg == '0) && err_reg)
        else $error("zero pressure level carries a nonzero term");

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy || div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider active outside its sequencer step");

    a_term_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        term_stat.busy || term_stat.done |-> (state_reg == ST_MUL))
        else $error("term unit active outside its sequencer step");

    a_one_level: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second beat accepted while a level is in work");

endmodule

`default_nettype wire

/* hdl/hgs_div.sv */
// ---------------------------------------------------------------------------
// Radix-2 ratio divider
// Restoring divider: one quotient bit per cycle of (dividend * 2^24) / divisor,
// for a quotient known to fit in the Q2.24 ratio.
// ---------------------------------------------------------------------------
`default_nettype none

module hgs_div
    import hgs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DATA_W-1:0]  dividend,
    input  wire logic [DATA_W-1:0]  divisor,
    output unit_status_t            stat,
    output logic [RATIO_W-1:0]      quotient
);

    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    div_reg;
    logic [1:0]           low_reg;
    logic [RATIO_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;

    // Shift in the next dividend bit; only the two low bits of the
    // thickness remain below the shifted ratio point, the rest are zero.
    assign trial = {rem_reg, low_reg[1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == DIV_CNT_W'(RATIO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // upper dividend bits give a partial remainder below the divisor
            rem_reg <= {2'b00, dividend[DATA_W-1:2]};
            low_reg <= dividend[1:0];
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[DATA_W+1]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[RATIO_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[RATIO_W-2:0], 1'b0};
            end
            low_reg <= {low_reg[0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

/* hdl/hgs_term.sv */
// ---------------------------------------------------------------------------
// Layer term unit
// One shared 32x32 multiplier forms floor(R * T * ratio / 2^36) over
// three products, saturated to the positive Q32.16 range.
// ---------------------------------------------------------------------------
`default_nettype none

module hgs_term
    import hgs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DATA_W-1:0]  gas_constant,
    input  wire logic [DATA_W-1:0]  virtual_temp,
    input  wire logic [RATIO_W-1:0] ratio,
    output unit_status_t            stat,
    output logic [TERM_W-1:0]       term
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int PART_W = DATA_W + RATIO_W;

    logic [DATA_W-1:0]  gc_reg;
    logic [DATA_W-1:0]  tv_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [DATA_W-1:0]  rt_hi_reg;
    logic [RATIO_W-1:0] lo_top_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TERM_W-1:0]  term_reg;
    logic [1:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PART_W:0]   upper;

    always_comb begin
        case (cnt_reg)
            2'd0: begin
                mul_a = gc_reg;
                mul_b = tv_reg;
            end
            2'd1: begin
                mul_a = prod_reg[DATA_W-1:0];
                mul_b = {{(DATA_W-RATIO_W){1'b0}}, ratio_reg};
            end
            default: begin
                mul_a = rt_hi_reg;
                mul_b = {{(DATA_W-RATIO_W){1'b0}}, ratio_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // high partial product plus the carry part of the low one; the low
    // 32 bits of the low product fall below the 2^36 scale point
    assign upper = {1'b0, prod_reg[PART_W-1:0]}
                 + {{(DATA_W+1){1'b0}}, lo_top_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            gc_reg    <= gas_constant;
            tv_reg    <= virtual_temp;
            ratio_reg <= ratio;
        end else if (busy_reg) begin
            case (cnt_reg)
                2'd0: prod_reg <= mul_p;
                2'd1: begin
                    rt_hi_reg <= prod_reg[PROD_W-1:DATA_W];
                    prod_reg  <= mul_p;
                end
                2'd2: begin
                    lo_top_reg <= prod_reg[PART_W-1:DATA_W];
                    prod_reg   <= mul_p;
                end
                default: begin
                    if (|upper[PART_W:TERM_W+4]) begin
                        term_reg <= '1;
                    end else begin
                        term_reg <= upper[TERM_W+3:4];
                    end
                end
            endcase
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign term      = term_reg;

endmodule

`default_nettype wire
